FILE: hdl/itdt_pkg.sv
`default_nettype none

package itdt_pkg;

  // Field widths of one item.
  localparam int VALUE_W      = 64;
  localparam int RADIX_W      = 5;
  localparam int PREC_W       = 6;
  localparam int CHAR_W       = 8;
  localparam int DIGIT_W      = 4;
  localparam int MAX_CHARS_DEF = 64;

  // The divider retires this many dividend bits per cycle.
  localparam int BITS_PER_CYC = 8;
  localparam int STEPS        = VALUE_W / BITS_PER_CYC;
  localparam int STEP_W       = $clog2(STEPS);

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

  typedef enum logic [1:0] {
    CMD_SDEC = 2'd0,
    CMD_U32  = 2'd1,
    CMD_U64  = 2'd2
  } conv_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PREP,
    ST_LOAD,
    ST_WAIT
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic start;
    logic div_en;
    logic prep;
    logic load;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic conv_done;
    logic out_last;
  } dp_sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] base;
    if (d < DIGIT_TEN) begin
      digit_char = CHAR_ZERO + CHAR_W'(d);
    end else begin
      base = upper ? CHAR_UP_A : CHAR_LOW_A;
      digit_char = base + CHAR_W'(d - DIGIT_TEN);
    end
  endfunction

endpackage

`default_nettype wire

FILE: hdl/itdt_ctrl.sv
`default_nettype none

module itdt_ctrl import itdt_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output dp_cmd_t      cmd_o,
  input  wire dp_sts_t sts_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_en = 1'b1;
        if (sts_i.conv_done) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_WAIT;
      end
      ST_WAIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.out_last) begin
            state_d = ST_IDLE;
          end else begin
            // Next character is loaded in the cycle the current one leaves.
            cmd_o.load = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/itdt_dp.sv
`default_nettype none

module itdt_dp import itdt_pkg::*; #(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dp_cmd_t            cmd_i,
  output dp_sts_t                 sts_o,
  input  wire logic [1:0]         command_i,
  input  wire logic [VALUE_W-1:0] value_i,
  input  wire logic [RADIX_W-1:0] radix_i,
  input  wire logic               uppercase_i,
  input  wire logic [PREC_W-1:0]  min_digits_i,
  output logic [CHAR_W-1:0]       character_o,
  output logic                    last_o
);

  localparam int CNT_W  = $clog2(MAX_CHARS + 1);
  localparam int ADDR_W = $clog2(MAX_CHARS);
  localparam int CMP_W  = (CNT_W > PREC_W) ? CNT_W : PREC_W;

  logic [VALUE_W-1:0]      rem_q;
  logic [RADIX_W-1:0]      rad_q;
  logic                    upper_q;
  logic [PREC_W-1:0]       prec_q;
  logic                    neg_q, negpend_q;
  logic [DIGIT_W-1:0]      r_q;
  logic [STEP_W-1:0]       step_q;
  logic                    qnz_q;
  logic [CNT_W-1:0]        cnt_q, left_q;
  logic [ADDR_W-1:0]       ptr_q;
  logic [DIGIT_W-1:0]      rdata_q;
  logic [CHAR_W-1:0]       char_q;
  logic                    last_q;
  logic [DIGIT_W-1:0]      mem [MAX_CHARS];

  // Input decode.
  logic [VALUE_W-1:0] mag;
  logic               neg;
  logic [RADIX_W-1:0] rad;
  logic [31:0]        lo;

  always_comb begin
    lo  = value_i[31:0];
    neg = 1'b0;
    mag = value_i;
    rad = radix_i;
    if (radix_i < RADIX_MIN) begin
      rad = RADIX_MIN;
    end else if (radix_i > RADIX_MAX) begin
      rad = RADIX_MAX;
    end
    unique case (conv_cmd_e'(command_i))
      CMD_SDEC: begin
        neg = lo[31];
        mag = {32'd0, (lo[31] ? (32'd0 - lo) : lo)};
        rad = RADIX_DEC;
      end
      CMD_U32: begin
        mag = {32'd0, lo};
      end
      default: begin
        mag = value_i;
      end
    endcase
  end

  // Eight restoring-division steps on the top byte of the dividend.
  logic [BITS_PER_CYC-1:0] qb;
  logic [DIGIT_W-1:0]      r_nx;
  logic [DIGIT_W:0]        t;

  always_comb begin
    qb   = '0;
    r_nx = r_q;
    t    = '0;
    for (int k = 0; k < BITS_PER_CYC; k++) begin
      t = {r_nx, rem_q[VALUE_W-1-k]};
      if (t >= {1'b0, rad_q[DIGIT_W-1:0]} || rad_q[DIGIT_W]) begin
        if (t >= {1'b0, rad_q[DIGIT_W-1:0]} && !rad_q[DIGIT_W]) begin
          t = t - {1'b0, rad_q[DIGIT_W-1:0]};
          qb[BITS_PER_CYC-1-k] = 1'b1;
        end else if (t[DIGIT_W]) begin
          t = t - {rad_q};
          qb[BITS_PER_CYC-1-k] = 1'b1;
        end
      end
      r_nx = t[DIGIT_W-1:0];
    end
  end

  logic             digit_done, q_nz, stop;
  logic [CNT_W-1:0] cnt_nx, limit, cnt_m1;

  assign digit_done = (step_q == STEP_W'(STEPS - 1));
  assign q_nz       = qnz_q | (|qb);
  assign cnt_nx     = cnt_q + 1'b1;
  assign cnt_m1     = cnt_q - 1'b1;
  assign limit      = CNT_W'(MAX_CHARS) - CNT_W'(neg_q);
  assign stop       = digit_done &&
                      ((!q_nz && (CMP_W'(cnt_nx) >= CMP_W'(prec_q))) || (cnt_nx == limit));

  assign sts_o.conv_done = cmd_i.div_en && stop;
  assign sts_o.out_last  = last_q;

  // Digit memory read: first digit on prep, the following ones as digits leave.
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              load_digit;

  assign load_digit = cmd_i.load && !negpend_q;
  assign rd_en      = cmd_i.prep || (load_digit && (left_q > CNT_W'(1)));
  assign rd_addr    = cmd_i.prep ? cnt_m1[ADDR_W-1:0] : (ptr_q - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= '0;
      r_q       <= '0;
      qnz_q     <= 1'b0;
      cnt_q     <= '0;
      neg_q     <= 1'b0;
      negpend_q <= 1'b0;
      left_q    <= '0;
    end else begin
      if (cmd_i.start) begin
        step_q    <= '0;
        r_q       <= '0;
        qnz_q     <= 1'b0;
        cnt_q     <= '0;
        neg_q     <= neg;
        negpend_q <= neg;
      end else if (cmd_i.div_en) begin
        step_q <= step_q + 1'b1;
        if (digit_done) begin
          cnt_q <= cnt_nx;
          r_q   <= '0;
          qnz_q <= 1'b0;
        end else begin
          r_q   <= r_nx;
          qnz_q <= q_nz;
        end
      end
      if (cmd_i.prep) begin
        left_q <= cnt_q;
      end else if (load_digit) begin
        left_q <= left_q - 1'b1;
      end
      if (cmd_i.load && negpend_q) begin
        negpend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rem_q   <= mag;
      rad_q   <= rad;
      upper_q <= uppercase_i;
      prec_q  <= min_digits_i;
    end else if (cmd_i.div_en) begin
      rem_q <= {rem_q[VALUE_W-BITS_PER_CYC-1:0], qb};
    end
    if (cmd_i.div_en && digit_done) begin
      mem[cnt_q[ADDR_W-1:0]] <= r_nx;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
      ptr_q   <= rd_addr;
    end
    if (cmd_i.load) begin
      if (negpend_q) begin
        char_q <= CHAR_MINUS;
        last_q <= 1'b0;
      end else begin
        char_q <= digit_char(rdata_q, upper_q);
        last_q <= (left_q == CNT_W'(1));
      end
    end
  end

  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

FILE: hdl/integer_to_digit_text.sv
// Sequence: an accepted item runs the divider over the whole dividend once per produced digit
// (digit count is the larger of the natural length and min_digits, capped at MAX_CHARS with the
// sign), then passes the prep and load states before the first character is offered, then
// sends one character per cycle while ready. Only one item is taken at a time; a minus sign
// adds one character. The byte-per-cycle shared divider and the character output set the pace.
// Reset (asynchronous, active low) returns the controller to idle; digit memory is not cleared.
`default_nettype none

module integer_to_digit_text import itdt_pkg::*; #(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input items.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [63:0] value, [68:64] radix, [69] uppercase, [75:70] min_digits, [79:76] zero
  input  wire logic [79:0] s_axis_tdata,
  // [1:0] command
  input  wire logic [1:0]  s_axis_tuser,
  // Result items.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] character
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tlast
);

  // The controller sequences load, division, memory read and output hand-off;
  // the datapath holds the dividend, the shared divider and the digit memory.
  dp_cmd_t cmd;
  dp_sts_t sts;

  itdt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Digits are produced least significant first into the memory, then read
  // back in reverse order. A pending minus sign is sent ahead of the digits.
  itdt_dp #(
    .MAX_CHARS (MAX_CHARS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .command_i    (s_axis_tuser),
    .value_i      (s_axis_tdata[63:0]),
    .radix_i      (s_axis_tdata[68:64]),
    .uppercase_i  (s_axis_tdata[69]),
    .min_digits_i (s_axis_tdata[75:70]),
    .character_o  (m_axis_tdata),
    .last_o       (m_axis_tlast)
  );

endmodule

`default_nettype wire

FILE: hdl/itdt_chk.sv
`default_nettype none

module itdt_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);

  // An accepted item occupies the block: no second item right behind it.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again right after an accepted item");

  // Input is never taken while text is still being sent.
  a_no_input_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while a character is pending");

  // The final character closes the conversion.
  a_quiet_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("output valid right after the final character");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output changed while stalled");

endmodule

bind integer_to_digit_text itdt_chk u_itdt_chk (.*);

`default_nettype wire
